// File: src/ring_neighbour_exclusion_arbiter_unit_assert.svh
// assertion macros for the ring arbiter
`ifndef RING_NEIGHBOUR_EXCLUSION_ARBITER_UNIT_ASSERT_SVH
`define RING_NEIGHBOUR_EXCLUSION_ARBITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define RNEA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define RNEA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) else $error(msg);
`else
`define RNEA_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define RNEA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

// File: src/rnea_pkg.sv
package rnea_pkg;

  localparam int SEAT_W = 4;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] SEAT_COUNT_RST = 5'd5;
  localparam logic [CNT_W-1:0] RING_MIN       = 5'd2;

  // register index taken from paddr[2]
  localparam logic REG_SEAT_COUNT = 1'b0;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] MAX_GRANTS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_LOAD,
    S_MOD,
    S_CHECK,
    S_FINISH
  } state_t;

  function automatic logic [CNT_W-1:0] ring_left(input logic [CNT_W-1:0] pos,
                                                 input logic [CNT_W-1:0] n);
    return (pos == '0) ? n - 1'b1 : pos - 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] ring_right(input logic [CNT_W-1:0] pos,
                                                  input logic [CNT_W-1:0] n);
    return (pos == n - 1'b1) ? '0 : pos + 1'b1;
  endfunction

endpackage

// File: src/ring_neighbour_exclusion_arbiter_unit.sv
// Ring arbiter for seats that each share a resource with both neighbours. A request
// (operation 0) is granted at once when neither neighbour is served, else the seat joins
// a wait queue; a request from a seat already waiting or served gives no word. A release
// (operation 1) idles the seat, drops it from the queue if it was waiting, then walks the
// queue in arrival order granting up to two seats whose neighbours are free, compacting
// the queue in the same pass. A seat not below the ring size gives one error word. The
// ring size is seat_count (register at address 0) saturated into [2, MAX_SEATS]; write it
// only while the block is idle. One word is handled at a time. The result of a request or
// an error is formed in the decode state and registered in the output register. For each
// queued entry a release costs one read of the queue memory, which has separate read and
// write ports, a registered read, an iterative modulo step per ring wrap and a decision
// that may write it back. Stalls on the result side can hold the decode, check and finish
// states. A result waiting in the output register does not keep the next word from being
// accepted.
module ring_neighbour_exclusion_arbiter_unit
  import rnea_pkg::*;
#(
  parameter int MAX_SEATS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [SEAT_W-1:0] in_seat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEAT_W-1:0] out_granted_seat,
  output logic              out_error,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int QW = $clog2(MAX_SEATS);

  logic [CNT_W-1:0]  ring_size;
  logic              q_we;
  logic [QW-1:0]     q_waddr;
  logic [SEAT_W-1:0] q_wdata;
  logic              q_re;
  logic [QW-1:0]     q_raddr;
  logic [SEAT_W-1:0] q_rdata;

  rnea_cfg #(
    .MAX_SEATS(MAX_SEATS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .ring_size(ring_size)
  );

  rnea_queue #(
    .MAX_SEATS(MAX_SEATS)
  ) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .re   (q_re),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  rnea_ctrl #(
    .MAX_SEATS(MAX_SEATS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .ring_size       (ring_size),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_seat         (in_seat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted_seat(out_granted_seat),
    .out_error       (out_error),
    .out_last        (out_last),
    .q_we            (q_we),
    .q_waddr         (q_waddr),
    .q_wdata         (q_wdata),
    .q_re            (q_re),
    .q_raddr         (q_raddr),
    .q_rdata         (q_rdata)
  );

endmodule

// File: src/rnea_cfg.sv
module rnea_cfg
  import rnea_pkg::*;
#(
  parameter int MAX_SEATS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  ring_size
);

  logic [CNT_W-1:0] seat_count_r;
  logic [CNT_W-1:0] seat_count_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SEAT_COUNT);

  always_comb begin
    seat_count_nxt = seat_count_r;
    if (wr_en) begin
      seat_count_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seat_count_r <= SEAT_COUNT_RST;
    end else begin
      seat_count_r <= seat_count_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_SEAT_COUNT) ? DATA_W'(seat_count_r) : '0;

  // saturate into [2, MAX_SEATS]
  always_comb begin
    priority if (seat_count_r < RING_MIN) begin
      ring_size = RING_MIN;
    end else if (32'(seat_count_r) > MAX_SEATS) begin
      ring_size = CNT_W'(MAX_SEATS);
    end else begin
      ring_size = seat_count_r;
    end
  end

endmodule

// File: src/rnea_queue.sv
module rnea_queue
  import rnea_pkg::*;
#(
  parameter int MAX_SEATS = 16,
  localparam int QW = $clog2(MAX_SEATS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [QW-1:0]     waddr,
  input  logic [SEAT_W-1:0] wdata,
  input  logic              re,
  input  logic [QW-1:0]     raddr,
  output logic [SEAT_W-1:0] rdata
);

  logic [SEAT_W-1:0] mem [MAX_SEATS];
  logic [SEAT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // compaction never lets the write pointer pass the read pointer, so no same-entry overlap
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/rnea_ctrl.sv
`include "ring_neighbour_exclusion_arbiter_unit_assert.svh"

module rnea_ctrl
  import rnea_pkg::*;
#(
  parameter int MAX_SEATS = 16,
  localparam int SW  = $clog2(MAX_SEATS),
  localparam int QW  = $clog2(MAX_SEATS),
  localparam int QLW = $clog2(MAX_SEATS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  ring_size,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [SEAT_W-1:0] in_seat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEAT_W-1:0] out_granted_seat,
  output logic              out_error,
  output logic              out_last,
  output logic              q_we,
  output logic [QW-1:0]     q_waddr,
  output logic [SEAT_W-1:0] q_wdata,
  output logic              q_re,
  output logic [QW-1:0]     q_raddr,
  input  logic [SEAT_W-1:0] q_rdata
);

  state_t            state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [SEAT_W-1:0] seat_r, seat_nxt;
  logic [SEAT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  red_r, red_nxt;
  logic [QLW-1:0]    rd_r, rd_nxt;
  logic [QLW-1:0]    wr_r, wr_nxt;
  logic [QLW-1:0]    qlen_r, qlen_nxt;
  logic [1:0]        gcnt_r, gcnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [SEAT_W-1:0] pend_seat_r, pend_seat_nxt;
  logic              withdraw_r, withdraw_nxt;
  logic [MAX_SEATS-1:0] served_r, served_nxt;
  logic [MAX_SEATS-1:0] waiting_r, waiting_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SEAT_W-1:0] out_seat_r, out_seat_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot;
  logic              seat_in;
  logic [SW-1:0]     seat_idx;
  logic [SW-1:0]     k_idx;
  logic              k_ok;
  logic              qfull;
  logic [CNT_W-1:0]  req_l, req_r, chk_l, chk_r;
  logic              req_free, chk_free;
  logic              emit;
  logic [SEAT_W-1:0] e_seat;
  logic              e_err;
  logic              e_last;

  assign slot     = !out_valid_r || out_ready;
  assign seat_in  = CNT_W'(seat_r) < ring_size;
  assign seat_idx = SW'(seat_r);
  assign k_idx    = SW'(k_r);
  assign k_ok     = 32'(k_r) < MAX_SEATS;
  assign qfull    = qlen_r >= QLW'(MAX_SEATS);

  // request seat is below the ring size, queued seats are reduced first
  assign req_l    = ring_left(CNT_W'(seat_r), ring_size);
  assign req_r    = ring_right(CNT_W'(seat_r), ring_size);
  assign chk_l    = ring_left(red_r, ring_size);
  assign chk_r    = ring_right(red_r, ring_size);
  assign req_free = !served_r[SW'(req_l)] && !served_r[SW'(req_r)];
  assign chk_free = !served_r[SW'(chk_l)] && !served_r[SW'(chk_r)];

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_seat = out_seat_r;
  assign out_error        = out_err_r;
  assign out_last         = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    seat_nxt      = seat_r;
    k_nxt         = k_r;
    red_nxt       = red_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    qlen_nxt      = qlen_r;
    gcnt_nxt      = gcnt_r;
    pend_v_nxt    = pend_v_r;
    pend_seat_nxt = pend_seat_r;
    withdraw_nxt  = withdraw_r;
    served_nxt    = served_r;
    waiting_nxt   = waiting_r;
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = '0;
    q_re          = 1'b0;
    q_raddr       = '0;
    emit          = 1'b0;
    e_seat        = '0;
    e_err         = 1'b0;
    e_last        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          seat_nxt  = in_seat;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (!seat_in) begin
          if (slot) begin
            emit      = 1'b1;
            e_err     = 1'b1;
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (op_r == OP_REQUEST) begin
          priority if (served_r[seat_idx] || waiting_r[seat_idx]) begin
            state_nxt = S_IDLE;
          end else if (req_free) begin
            if (slot) begin
              emit                 = 1'b1;
              e_seat               = seat_r;
              e_last               = 1'b1;
              served_nxt[seat_idx] = 1'b1;
              state_nxt            = S_IDLE;
            end
          end else if (!qfull) begin
            waiting_nxt[seat_idx] = 1'b1;
            q_we                  = 1'b1;
            q_waddr               = qlen_r[QW-1:0];
            q_wdata               = seat_r;
            qlen_nxt              = qlen_r + 1'b1;
            state_nxt             = S_IDLE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          // release: a waiting seat is dropped from the queue during the scan
          withdraw_nxt          = waiting_r[seat_idx];
          served_nxt[seat_idx]  = 1'b0;
          waiting_nxt[seat_idx] = 1'b0;
          rd_nxt                = '0;
          wr_nxt                = '0;
          gcnt_nxt              = '0;
          pend_v_nxt            = 1'b0;
          state_nxt             = S_READ;
        end
      end
      S_READ: begin
        if (rd_r < qlen_r) begin
          q_re      = 1'b1;
          q_raddr   = rd_r[QW-1:0];
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_LOAD: begin
        k_nxt     = q_rdata;
        red_nxt   = CNT_W'(q_rdata);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // seat modulo ring size, one subtraction per cycle
        if (red_r >= ring_size) begin
          red_nxt = red_r - ring_size;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (withdraw_r && (k_r == seat_r)) begin
          rd_nxt    = rd_r + 1'b1;
          state_nxt = S_READ;
        end else if ((gcnt_r != MAX_GRANTS) && k_ok && waiting_r[k_idx] && chk_free) begin
          // hold each grant until we know whether another one follows
          if (!pend_v_r || slot) begin
            if (pend_v_r) begin
              emit   = 1'b1;
              e_seat = pend_seat_r;
            end
            served_nxt[k_idx]  = 1'b1;
            waiting_nxt[k_idx] = 1'b0;
            pend_v_nxt         = 1'b1;
            pend_seat_nxt      = k_r;
            gcnt_nxt           = gcnt_r + 1'b1;
            rd_nxt             = rd_r + 1'b1;
            state_nxt          = S_READ;
          end
        end else begin
          q_we      = 1'b1;
          q_waddr   = wr_r[QW-1:0];
          q_wdata   = k_r;
          wr_nxt    = wr_r + 1'b1;
          rd_nxt    = rd_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_FINISH: begin
        if (!pend_v_r || slot) begin
          if (pend_v_r) begin
            emit   = 1'b1;
            e_seat = pend_seat_r;
            e_last = 1'b1;
          end
          qlen_nxt   = wr_r;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_seat_nxt  = out_seat_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_seat_nxt  = e_seat;
      out_err_nxt   = e_err;
      out_last_nxt  = e_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_r        <= '0;
      wr_r        <= '0;
      qlen_r      <= '0;
      gcnt_r      <= '0;
      pend_v_r    <= 1'b0;
      withdraw_r  <= 1'b0;
      served_r    <= '0;
      waiting_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      qlen_r      <= qlen_nxt;
      gcnt_r      <= gcnt_nxt;
      pend_v_r    <= pend_v_nxt;
      withdraw_r  <= withdraw_nxt;
      served_r    <= served_nxt;
      waiting_r   <= waiting_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    seat_r      <= seat_nxt;
    k_r         <= k_nxt;
    red_r       <= red_nxt;
    pend_seat_r <= pend_seat_nxt;
    out_seat_r  <= out_seat_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  `RNEA_ASSERT(a_flags_excl, clk, rst_n, (served_r & waiting_r) == '0,
               "seat served and waiting at once")
  `RNEA_ASSERT(a_qlen_match, clk, rst_n,
               (state_r == S_IDLE) |-> ($countones(waiting_r) == int'(qlen_r)),
               "queue length differs from waiting seats")
  `RNEA_ASSERT(a_compact_order, clk, rst_n, wr_r <= rd_r,
               "compaction write pointer ahead of read pointer")
  `RNEA_ASSERT_NEXT(a_final_last, clk, rst_n, (state_r == S_FINISH) && pend_v_r && slot,
                    out_valid_r && out_last_r && !out_err_r,
                    "final grant of a release not marked last")

endmodule
